// ===== sv/length_prefixed_packet_fifo_unit_assert.svh =====
// Assertion macros for the length-prefixed packet FIFO unit.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef LENGTH_PREFIXED_PACKET_FIFO_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_FIFO_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that prop holds at every clock edge outside reset.
`define LPF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cause is followed by effect at the next clock edge.
`define LPF_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`else

`define LPF_ASSERT(label, clk, rst, prop, msg)
`define LPF_ASSERT_NEXT(label, clk, rst, cause, effect, msg)

`endif

`endif

// ===== sv/lpf_pkg.sv =====
// Shared types and constants for the length-prefixed packet FIFO unit.
// No dependencies.
`timescale 1ns / 1ps

package lpf_pkg;

  localparam int LPF_BUFFER_BYTES = 1024;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_TOO_BIG  = 3'd3,
    ST_SEQUENCE = 3'd4
  } status_t;

endpackage

// ===== sv/length_prefixed_packet_fifo_unit.sv =====
// Length-prefixed packet FIFO: byte ring plus a queue of item lengths.
// Result regs s1, out; one transfer per cycle while in_stall is low.
// Throughput is set by the ring's single read port and single write port.
// Reset clears pointers, counts and open flags; ring and length memories are
// not cleared and need no clearing pass (only complete items are ever read).
// Depends on lpf_pkg and length_prefixed_packet_fifo_unit_assert.svh.
`timescale 1ns / 1ps
`include "length_prefixed_packet_fifo_unit_assert.svh"

module length_prefixed_packet_fifo_unit #(
  parameter int BUFFER_BYTES = lpf_pkg::LPF_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [9:0] item_length,
  input  logic [7:0] data_byte,
  input  logic [9:0] reader_capacity,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] out_byte,
  output logic [9:0] out_length,
  output logic       last,
  output logic [9:0] stored_items
);
  import lpf_pkg::*;

  localparam int PW  = $clog2(BUFFER_BYTES);
  localparam int UW  = $clog2(BUFFER_BYTES + 1);
  localparam int SW  = ((UW > 10) ? UW : 10) + 1;
  localparam int LD  = BUFFER_BYTES / 2;
  localparam int LAW = $clog2(LD);
  localparam int CW  = $clog2(LD + 1);

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] pos, input logic [1:0] inc);
    logic [PW:0] s;
    s = {1'b0, pos} + (PW+1)'(inc);
    if (s >= (PW+1)'(BUFFER_BYTES)) begin
      s = s - (PW+1)'(BUFFER_BYTES);
    end
    return s[PW-1:0];
  endfunction

  function automatic logic [LAW-1:0] lptr_inc(input logic [LAW-1:0] p);
    return (p == LAW'(LD - 1)) ? '0 : p + LAW'(1);
  endfunction

  logic [7:0]     ring [BUFFER_BYTES];
  logic [9:0]     len_mem [LD];

  logic [PW-1:0]  wp, rp, wp_next, rp_next;
  logic [UW-1:0]  used_bytes, used_bytes_next;
  logic [CW-1:0]  item_count, item_count_next;
  logic [9:0]     write_bytes_left, write_bytes_left_next;
  logic           write_open, write_open_next;
  logic [9:0]     read_bytes_left, read_bytes_left_next;
  logic           read_open, read_open_next;
  logic [9:0]     read_item_length, read_item_length_next;
  logic [LAW-1:0] lw, lr, lw_next, lr_next;
  logic [9:0]     head_len;
  logic [7:0]     ring_q;

  logic           accept;
  logic           ring_we, ring_re, len_we;
  logic [PW-1:0]  ring_raddr;
  logic [SW-1:0]  need;
  status_t        st;
  logic [9:0]     olen;
  logic           lst, bsel;

  logic           s1_valid, s1_advance;
  status_t        s1_status;
  logic [9:0]     s1_len;
  logic           s1_last, s1_bsel;
  logic [CW-1:0]  s1_count;
  status_t        out_status;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;
  assign need       = SW'(used_bytes) + SW'(item_length) + SW'(2);

  always_comb begin
    st                    = ST_OK;
    olen                  = '0;
    lst                   = 1'b0;
    bsel                  = 1'b0;
    ring_we               = 1'b0;
    ring_re               = 1'b0;
    ring_raddr            = rp;
    len_we                = 1'b0;
    wp_next               = wp;
    rp_next               = rp;
    used_bytes_next       = used_bytes;
    item_count_next       = item_count;
    write_open_next       = write_open;
    write_bytes_left_next = write_bytes_left;
    read_open_next        = read_open;
    read_bytes_left_next  = read_bytes_left;
    read_item_length_next = read_item_length;
    lw_next               = lw;
    lr_next               = lr;
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          if (write_open) begin
            st = ST_SEQUENCE;
          end else if (need > SW'(BUFFER_BYTES)) begin
            st = ST_NO_SPACE;
          end else begin
            len_we          = 1'b1;
            lw_next         = lptr_inc(lw);
            wp_next         = wrap_add(wp, 2'd2);
            used_bytes_next = UW'(need);
            if (item_length == '0) begin
              item_count_next = item_count + CW'(1);
              lst             = 1'b1;
            end else begin
              write_open_next       = 1'b1;
              write_bytes_left_next = item_length;
            end
          end
        end
        CMD_DATA: begin
          if (!write_open) begin
            st = ST_SEQUENCE;
          end else begin
            ring_we               = 1'b1;
            wp_next               = wrap_add(wp, 2'd1);
            write_bytes_left_next = write_bytes_left - 10'd1;
            if (write_bytes_left == 10'd1) begin
              write_open_next = 1'b0;
              item_count_next = item_count + CW'(1);
              lst             = 1'b1;
            end
          end
        end
        CMD_READ: begin
          if (read_open) begin
            olen                 = read_item_length;
            bsel                 = 1'b1;
            ring_re              = 1'b1;
            ring_raddr           = rp;
            rp_next              = wrap_add(rp, 2'd1);
            used_bytes_next      = used_bytes - UW'(1);
            read_bytes_left_next = read_bytes_left - 10'd1;
            if (read_bytes_left == 10'd1) begin
              read_open_next  = 1'b0;
              item_count_next = item_count - CW'(1);
              lst             = 1'b1;
            end
          end else if (item_count == '0) begin
            st = ST_EMPTY;
          end else begin
            olen = head_len;
            if (head_len > reader_capacity) begin
              st = ST_TOO_BIG;
            end else if (head_len == '0) begin
              lr_next         = lptr_inc(lr);
              rp_next         = wrap_add(rp, 2'd2);
              used_bytes_next = used_bytes - UW'(2);
              item_count_next = item_count - CW'(1);
              lst             = 1'b1;
            end else begin
              lr_next         = lptr_inc(lr);
              bsel            = 1'b1;
              ring_re         = 1'b1;
              ring_raddr      = wrap_add(rp, 2'd2);
              rp_next         = wrap_add(rp, 2'd3);
              used_bytes_next = used_bytes - UW'(3);
              if (head_len == 10'd1) begin
                item_count_next = item_count - CW'(1);
                lst             = 1'b1;
              end else begin
                read_open_next        = 1'b1;
                read_item_length_next = head_len;
                read_bytes_left_next  = head_len - 10'd1;
              end
            end
          end
        end
        default: begin
          st = ST_SEQUENCE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wp] <= data_byte;
    end
    if (ring_re) begin
      ring_q <= ring[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[lw] <= item_length;
    end
    head_len <= (len_we && (lw == lr_next)) ? item_length : len_mem[lr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp               <= '0;
      rp               <= '0;
      used_bytes       <= '0;
      item_count       <= '0;
      write_open       <= 1'b0;
      write_bytes_left <= '0;
      read_open        <= 1'b0;
      read_bytes_left  <= '0;
      read_item_length <= '0;
      lw               <= '0;
      lr               <= '0;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      wp               <= wp_next;
      rp               <= rp_next;
      used_bytes       <= used_bytes_next;
      item_count       <= item_count_next;
      write_open       <= write_open_next;
      write_bytes_left <= write_bytes_left_next;
      read_open        <= read_open_next;
      read_bytes_left  <= read_bytes_left_next;
      read_item_length <= read_item_length_next;
      lw               <= lw_next;
      lr               <= lr_next;
      s1_valid         <= accept || (s1_valid && !s1_advance);
      out_valid        <= s1_advance || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st;
      s1_len    <= olen;
      s1_last   <= lst;
      s1_bsel   <= bsel;
      s1_count  <= item_count_next;
    end
    if (s1_advance) begin
      out_status   <= s1_status;
      out_byte     <= s1_bsel ? ring_q : 8'd0;
      out_length   <= s1_len;
      last         <= s1_last;
      stored_items <= 10'(s1_count);
    end
  end

  assign status = out_status;

  `LPF_ASSERT(a_used_bound, clk, rst, used_bytes <= UW'(BUFFER_BYTES), "used bytes exceed ring")
  `LPF_ASSERT(a_write_left, clk, rst, !write_open || (write_bytes_left != '0), "open write has no bytes left")
  `LPF_ASSERT(a_read_count, clk, rst, !read_open || (item_count != '0), "open read with no stored item")
  `LPF_ASSERT(a_stall_cause, clk, rst, !in_stall || (out_valid && out_stall), "input stalled without output stall")
  `LPF_ASSERT_NEXT(a_empty_read, clk, rst, accept && (cmd == CMD_READ) && !read_open && (item_count == '0), s1_valid && (s1_status == ST_EMPTY), "read on empty queue not reported")

endmodule

// ===== tb/lpf_checker.sv =====
// Checker for the length-prefixed packet FIFO unit: watches both channels,
// predicts each result from its own ring model and compares. Depends on lpf_pkg.
`timescale 1ns / 1ps

module lpf_checker #(
  parameter int RING_BYTES = lpf_pkg::LPF_BUFFER_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [9:0] item_length,
  input  logic [7:0] data_byte,
  input  logic [9:0] reader_capacity,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] status,
  input  logic [7:0] out_byte,
  input  logic [9:0] out_length,
  input  logic       last,
  input  logic [9:0] stored_items,
  output int         fail_count,
  output int         pending
);
  import lpf_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [7:0] value;
    logic [9:0] length;
    logic       last;
    logic [9:0] items;
  } fifo_result_t;

  fifo_result_t expected_results[$];
  bit [7:0]     ring [RING_BYTES];
  int unsigned  rd_pos, wr_pos, used_bytes, item_count;
  int unsigned  write_left, read_left, read_len;
  bit           write_open, read_open;
  int           mismatches = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic int unsigned ring_next(int unsigned pos);
    return (pos + 1) % RING_BYTES;
  endfunction

  function automatic fifo_result_t fifo_step(logic [1:0] c, logic [9:0] len, logic [7:0] b,
                                             logic [9:0] cap);
    fifo_result_t r;
    int unsigned  hlen;
    r = '0;
    r.status = ST_OK;
    case (c)
      CMD_START: begin
        if (write_open) begin
          r.status = ST_SEQUENCE;
        end else if (len + 2 > RING_BYTES - used_bytes) begin
          r.status = ST_NO_SPACE;
        end else begin
          ring[wr_pos] = len[7:0];
          wr_pos = ring_next(wr_pos);
          ring[wr_pos] = {6'd0, len[9:8]};
          wr_pos = ring_next(wr_pos);
          used_bytes += len + 2;
          if (len == 0) begin
            item_count++;
            r.last = 1'b1;
          end else begin
            write_open = 1'b1;
            write_left = len;
          end
        end
      end
      CMD_DATA: begin
        if (!write_open) begin
          r.status = ST_SEQUENCE;
        end else begin
          ring[wr_pos] = b;
          wr_pos = ring_next(wr_pos);
          write_left--;
          if (write_left == 0) begin
            write_open = 1'b0;
            item_count++;
            r.last = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (!read_open) begin
          if (item_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            hlen = {ring[ring_next(rd_pos)], ring[rd_pos]};
            hlen = hlen & 'h3FF;
            r.length = 10'(hlen);
            if (hlen > cap) begin
              r.status = ST_TOO_BIG;
            end else begin
              rd_pos = ring_next(ring_next(rd_pos));
              used_bytes -= 2;
              if (hlen == 0) begin
                item_count--;
                r.last = 1'b1;
              end else begin
                read_open = 1'b1;
                read_len = hlen;
                read_left = hlen;
              end
            end
          end
        end
        if (read_open && r.status == ST_OK) begin
          r.length = 10'(read_len);
          r.value = ring[rd_pos];
          rd_pos = ring_next(rd_pos);
          used_bytes--;
          read_left--;
          if (read_left == 0) begin
            read_open = 1'b0;
            item_count--;
            r.last = 1'b1;
          end
        end
      end
      default: r.status = ST_SEQUENCE;
    endcase
    r.items = 10'(item_count);
    return r;
  endfunction

  task automatic note_failure(string what, fifo_result_t want, fifo_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected st=%0d byte=%02h len=%0d last=%0d items=%0d, got st=%0d byte=%02h len=%0d last=%0d items=%0d",
               $realtime, what, want.status, want.value, want.length, want.last, want.items,
               got.status, got.value, got.length, got.last, got.items);
  endtask

  always @(posedge clk) begin
    fifo_result_t want;
    fifo_result_t got;
    if (rst) begin
      expected_results.delete();
      rd_pos = 0;
      wr_pos = 0;
      used_bytes = 0;
      item_count = 0;
      write_left = 0;
      read_left = 0;
      read_len = 0;
      write_open = 1'b0;
      read_open = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(status);
        got.value = out_byte;
        got.length = out_length;
        got.last = last;
        got.items = stored_items;
        if (expected_results.size() == 0) begin
          note_failure("unexpected result transfer", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            note_failure("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(fifo_step(cmd, item_length, data_byte, reader_capacity));
    end
    pending <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the length-prefixed packet FIFO testbench: clock, reset, stimulus and verdict.
// Depends on lpf_pkg, lpf_checker and length_prefixed_packet_fifo_unit.
`timescale 1ns / 1ps

module tb_top;
  import lpf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CAP_MAX    = 1023;
  localparam int         HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] cmd = CMD_START;
  logic [9:0] item_length = '0;
  logic [7:0] data_byte = '0;
  logic [9:0] reader_capacity = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic [9:0] out_length;
  logic       last;
  logic [9:0] stored_items;

  int fail_count;
  int pending;
  int send_idle_pct = 11;
  int recv_stall_pct = 74;
  int sent_count = 0;
  bit pressure_go = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;

  length_prefixed_packet_fifo_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .item_length(item_length), .data_byte(data_byte),
    .reader_capacity(reader_capacity),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_byte(out_byte), .out_length(out_length),
    .last(last), .stored_items(stored_items)
  );

  lpf_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .item_length(item_length), .data_byte(data_byte),
    .reader_capacity(reader_capacity),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_byte(out_byte), .out_length(out_length),
    .last(last), .stored_items(stored_items),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("length_prefixed_packet_fifo_unit test failed");
    $finish;
  end

  // hold the result channel off for a long stretch once asked, else stall at random
  always @(posedge clk) begin
    if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic transfer_item(input logic [1:0] c, input int len, input int b, input int cap);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    item_length <= 10'(len);
    data_byte <= 8'(b);
    reader_capacity <= 10'(cap);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  function automatic int read_capacity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CAP_MAX;
    if (r < 95) return $urandom_range(0, CAP_MAX);
    return 0;
  endfunction

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: transfer_item(CMD_START, $urandom_range(0, 1023), $urandom_range(0, 255),
                       $urandom_range(0, CAP_MAX));
      1: transfer_item(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 255),
                       $urandom_range(0, CAP_MAX));
      2: transfer_item(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 255),
                       read_capacity());
      default: transfer_item(CMD_DATA, $urandom_range(0, 1023), $urandom_range(0, 255),
                             $urandom_range(0, CAP_MAX));
    endcase
  endtask

  // well-formed items with random content (the rare long ones get no data bytes), fill and drain stretches, some noise
  task automatic run_phase(input int target);
    int stop_at;
    int len;
    int reads;
    int r;
    int i;
    bit filling;
    stop_at = sent_count + target;
    filling = 1'b0;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 11) == 0)
        filling = !filling;
      if ($urandom_range(0, 99) < 4)
        send_noise();
      r = $urandom_range(0, 99);
      if (r < 3) len = $urandom_range(600, 1023);
      else if (r < 38) len = 0;
      else if (r < 75) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 40);
      transfer_item(CMD_START, len, $urandom_range(0, 255), $urandom_range(0, CAP_MAX));
      if (r >= 3) begin
        for (i = 0; i < len && sent_count < stop_at; i++) begin
          if ($urandom_range(0, 99) < 5)
            send_noise();
          transfer_item(CMD_DATA, $urandom_range(0, 1023), $urandom_range(0, 255),
                        $urandom_range(0, CAP_MAX));
        end
        reads = filling ? $urandom_range(0, 1) : len + $urandom_range(1, 3);
      end else begin
        reads = $urandom_range(0, 2);
      end
      for (i = 0; i < reads && sent_count < stop_at; i++)
        transfer_item(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 255),
                      read_capacity());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_DATA, 0, 8'h3C, CAP_MAX);
    transfer_item(CMD_UNUSED, 0, 0, 0);
    transfer_item(CMD_START, 1023, 0, 0);
    transfer_item(CMD_START, 0, 0, 0);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_START, 3, 0, 0);
    transfer_item(CMD_START, 5, 0, 0);
    transfer_item(CMD_DATA, 0, 8'h00, 0);
    transfer_item(CMD_DATA, 0, 8'hFF, 0);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_DATA, 0, 8'hA5, 0);
    transfer_item(CMD_READ, 0, 0, 2);
    transfer_item(CMD_READ, 0, 0, 0);
    transfer_item(CMD_READ, 0, 0, 3);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_START, 0, 0, 0);
    transfer_item(CMD_START, 1022, 0, 0);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);
    transfer_item(CMD_READ, 0, 0, CAP_MAX);

    run_phase(430);
    send_idle_pct = 74;
    recv_stall_pct = 11;
    run_phase(430);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pressure_go = 1'b1;
    run_phase(440);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("length_prefixed_packet_fifo_unit test passed");
    end else begin
      $display("length_prefixed_packet_fifo_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lpf_pkg.sv
sv/length_prefixed_packet_fifo_unit.sv
tb/lpf_checker.sv
tb/tb_top.sv
